// File: hdl/fca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, codes and helpers of the font checksum adjustment unit.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned LOG_W    = 4;
  localparam int unsigned POS_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] ADJUST_MAGIC = 32'hB1B0_AFBA;
  localparam logic [WORD_W-1:0] FLAVOR_RESET = 32'h0001_0000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FLAVOR      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT = 1'd1;

  // input item kinds
  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // result kinds
  localparam logic KIND_TABLE  = 1'b0;
  localparam logic KIND_ADJUST = 1'b1;

  // word index of the adjustment field inside the head table
  localparam logic [POS_W-1:0] ADJ_FIELD_POS = 2'd2;
  localparam logic [POS_W-1:0] POS_SAT       = 2'd3;

  // registered input beat
  typedef struct packed {
    logic              cmd;
    logic              last_word;
    logic              is_head;
    logic [WORD_W-1:0] data_word;
    logic [WORD_W-1:0] entry_sum;  // tag + offset + length
  } item_t;

  function automatic logic [LOG_W-1:0] floor_log2(input logic [COUNT_W-1:0] n);
    logic [LOG_W-1:0] p;
    p = '0;
    for (int i = 1; i < COUNT_W; i++) begin
      if (n[i]) p = LOG_W'(i);
    end
    return p;
  endfunction

endpackage

// File: hdl/fca_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_in_reg
// Input register: captures a beat and folds the directory entry fields.
// ----------------------------------------------------------------------------
module fca_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic                      advance,
  input  logic                      cmd,
  input  logic                      last_word,
  input  logic                      is_head,
  input  logic [fca_pkg::WORD_W-1:0] data_word,
  input  logic [fca_pkg::WORD_W-1:0] table_tag,
  input  logic [fca_pkg::WORD_W-1:0] table_offset,
  input  logic [fca_pkg::WORD_W-1:0] table_length,
  output fca_pkg::item_t            item_r,
  output logic                      valid_r
);
  import fca_pkg::*;

  item_t item_nxt;
  logic  valid_nxt;

  always_comb begin
    item_nxt.cmd       = cmd;
    item_nxt.last_word = last_word;
    item_nxt.is_head   = is_head;
    item_nxt.data_word = data_word;
    item_nxt.entry_sum = table_tag + table_offset + table_length;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: hdl/fca_header.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_header
// Configuration registers and the registered header term of the adjustment.
// ----------------------------------------------------------------------------
module fca_header (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fca_pkg::WORD_W-1:0]    cfg_wdata,
  output logic [fca_pkg::WORD_W-1:0]    adj_base_r
);
  import fca_pkg::*;

  logic [WORD_W-1:0]  flavor_r;
  logic [COUNT_W-1:0] table_count_r;
  logic [LOG_W-1:0]   log_n;
  logic [COUNT_W-1:0] srch_span;
  logic [COUNT_W-1:0] span_rem;
  logic [WORD_W-1:0]  header_sum;
  logic [WORD_W-1:0]  adj_base_nxt;
  logic [WORD_W+COUNT_W-1:0] sr_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flavor_r      <= FLAVOR_RESET;
      table_count_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FLAVOR:      flavor_r      <= cfg_wdata;
        CFG_TABLE_COUNT: table_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    log_n        = floor_log2(table_count_r);
    sr_wide      = (WORD_W+COUNT_W)'(16) << log_n;
    srch_span    = (table_count_r != '0) ? sr_wide[COUNT_W-1:0] : '0;
    span_rem     = {table_count_r[COUNT_W-5:0], 4'd0} - srch_span;
    header_sum   = flavor_r
                 + {table_count_r, srch_span}
                 + {{(WORD_W-COUNT_W-LOG_W){1'b0}}, log_n, span_rem};
    adj_base_nxt = ADJUST_MAGIC - header_sum;
  end

  // follow the configuration; the user keeps it static while items flow, the block does not enforce it
  always_ff @(posedge clk) begin
    adj_base_r <= adj_base_nxt;
  end

endmodule

// File: hdl/fca_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_accum
// Running sums and the result register of the checksum adjustment unit.
// ----------------------------------------------------------------------------
module fca_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fca_pkg::item_t            item_r,
  input  logic                      item_valid,
  input  logic                      advance,
  input  logic [fca_pkg::WORD_W-1:0] adj_base,
  output logic                      out_valid_r,
  output logic                      out_kind_r,
  output logic [fca_pkg::WORD_W-1:0] out_sum_r
);
  import fca_pkg::*;

  logic [WORD_W-1:0] table_sum_r, table_sum_nxt;
  logic [POS_W-1:0]  word_pos_r, word_pos_nxt;
  // file sum plus directory sum, kept as one total
  logic [WORD_W-1:0] total_r, total_nxt;
  logic              out_valid_nxt, out_kind_nxt;
  logic [WORD_W-1:0] out_sum_nxt;
  logic [WORD_W-1:0] word_eff, cs;
  logic              fire;

  assign fire = item_valid && advance;

  always_comb begin
    table_sum_nxt = table_sum_r;
    word_pos_nxt  = word_pos_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !advance;
    out_kind_nxt  = out_kind_r;
    out_sum_nxt   = out_sum_r;
    word_eff      = (item_r.is_head && word_pos_r == ADJ_FIELD_POS) ? '0 : item_r.data_word;
    cs            = table_sum_r + word_eff;
    if (fire) begin
      if (item_r.cmd == CMD_FINISH) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ADJUST;
        out_sum_nxt   = adj_base - total_r;
        table_sum_nxt = '0;
        word_pos_nxt  = '0;
        total_nxt     = '0;
      end else if (item_r.last_word) begin
        // checksum enters the file sum once and the directory entry once
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_TABLE;
        out_sum_nxt   = cs;
        table_sum_nxt = '0;
        word_pos_nxt  = '0;
        total_nxt     = total_r + item_r.entry_sum + {cs[WORD_W-2:0], 1'b0};
      end else begin
        table_sum_nxt = cs;
        if (word_pos_r != POS_SAT) word_pos_nxt = word_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_sum_r <= '0;
      word_pos_r  <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      table_sum_r <= table_sum_nxt;
      word_pos_r  <= word_pos_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_sum_r  <= out_sum_nxt;
  end

endmodule

// File: hdl/font_checksum_adjustment_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_checksum_adjustment_unit
// Streams font table words, emits per-table checksums and the final
// checksum adjustment.
// ----------------------------------------------------------------------------
// Each beat is registered on entry and then handled, as soon as the result
// register is free or drained, by one 32-bit add into the table sum, so one
// beat per clock is taken for as long as the result side keeps up; a result
// is registered in the result register as its beat leaves the input
// register. Data beats that are not the last word of a table give no
// result; a table's last word gives its checksum, and a finish beat gives
// the adjustment and clears all sums for the next font. The header term is
// registered from the flavor and table_count registers after a write.
// ----------------------------------------------------------------------------
module font_checksum_adjustment_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // slave side
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [127:0]                  in_tdata,  // data_word, table_tag, table_offset, table_length
  input  logic [1:0]                    in_tuser,  // cmd, is_head
  input  logic                          in_tlast,
  // master side
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata, // sum_value
  output logic                          out_tuser, // result_kind
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fca_pkg::WORD_W-1:0]    cfg_wdata
);
  import fca_pkg::*;

  item_t             item_r;
  logic              item_valid_r;
  logic              advance;
  logic              load;
  logic [WORD_W-1:0] adj_base_r;

  // the working stage moves whenever the result register is free or drained
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !item_valid_r || advance;
  assign load      = in_tvalid && in_tready;

  fca_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .advance      (advance),
    .cmd          (in_tuser[0]),
    .last_word    (in_tlast),
    .is_head      (in_tuser[1]),
    .data_word    (in_tdata[31:0]),
    .table_tag    (in_tdata[63:32]),
    .table_offset (in_tdata[95:64]),
    .table_length (in_tdata[127:96]),
    .item_r       (item_r),
    .valid_r      (item_valid_r)
  );

  fca_header u_header (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .adj_base_r (adj_base_r)
  );

  fca_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_r      (item_r),
    .item_valid  (item_valid_r),
    .advance     (advance),
    .adj_base    (adj_base_r),
    .out_valid_r (out_tvalid),
    .out_kind_r  (out_tuser),
    .out_sum_r   (out_tdata)
  );

endmodule
